FILE: hw/rtl/pcmrv_pkg.sv
// Shared constants, configuration register indexes and controller/datapath
// interface structs for the PCM resample, volume and mix block. No dependencies.
package pcmrv_pkg;

  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned FRAME_IDX_W     = 14;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned PHASE_W         = 18;
  localparam int unsigned GAIN_W          = 9;
  localparam int unsigned RES_CNT_W       = 5;
  localparam int unsigned DIV_W           = 48;
  localparam int unsigned DIV_CNT_W       = 6;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned BUFFER_FRAMES_DEF = 16384;

  localparam logic [15:0] TARGET_HZ       = 16'd48000;
  localparam logic [15:0] MIN_HZ          = 16'd8000;
  localparam logic [GAIN_W-1:0] GAIN_MAX  = 9'd256;
  localparam logic [PHASE_W-1:0] PHASE_ONE = 18'h10000;
  localparam logic [RES_CNT_W-1:0] MAX_RES = 5'd16;

  // step = (rate << 16) / 48000 = rate * 512 / 375, by reciprocal multiply
  localparam int unsigned STEP_PROD_W = 42;
  localparam int unsigned STEP_SHIFT  = 25;
  localparam logic [25:0] STEP_MUL    = 26'd45812985;

  localparam logic [15:0]       RATE_RESET   = 16'd48000;
  localparam logic [GAIN_W-1:0] VOLUME_RESET = 9'd154;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_SOURCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOCKED_HALVING = 2'd3;

  localparam logic OP_FRAME     = 1'b0;
  localparam logic OP_BEGIN_MIX = 1'b1;

  typedef struct packed {
    logic accept;
    logic begin_mix;
    logic div_go;
    logic div_take;
    logic lerp;
    logic hold;
    logic scale;
    logic read;
    logic write;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_mix_op;
    logic need_total;
    logic div_done;
    logic interp_more;
    logic hold_more;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/pcmrv_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pcmrv_pkg for widths.
module pcmrv_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  logic                           take_i,
  input  logic [pcmrv_pkg::DIV_W-1:0]    dividend_i,
  input  logic [15:0]                    divisor_i,
  output logic                           done_o,
  output logic [pcmrv_pkg::DIV_W-1:0]    quotient_o
);

  logic                               busy_q, busy_d;
  logic [pcmrv_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [pcmrv_pkg::DIV_W-1:0]        dvd_q, dvd_d;
  logic [15:0]                        rem_q, rem_d;
  logic [15:0]                        dvs_q, dvs_d;
  logic [16:0]                        trial;
  logic                               ge;

  always_comb begin
    trial  = {rem_q, dvd_q[pcmrv_pkg::DIV_W-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d  = pcmrv_pkg::DIV_CNT_W'(pcmrv_pkg::DIV_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (take_i) begin
      busy_d = 1'b0;
    end else if (busy_q && cnt_q != '0) begin
      rem_d = ge ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
      dvd_d = {dvd_q[pcmrv_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = busy_q && cnt_q == '0;
  assign quotient_o = dvd_q;

endmodule

FILE: hw/rtl/pcmrv_dp.sv
// Datapath: configuration registers, sound state, interpolate/scale/mix
// pipeline, play buffer and output register. Depends on pcmrv_pkg, pcmrv_div.
module pcmrv_dp #(
  parameter int unsigned BUFFER_FRAMES = pcmrv_pkg::BUFFER_FRAMES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcmrv_pkg::cmd_t                     cmd_i,
  output pcmrv_pkg::sts_t                     sts_o,
  input  logic                                operation_i,
  input  logic signed [15:0]                  left_sample_i,
  input  logic signed [15:0]                  right_sample_i,
  input  logic                                final_frame_i,
  input  logic                                cfg_we_i,
  input  logic [pcmrv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcmrv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [pcmrv_pkg::FRAME_IDX_W-1:0]   frame_index_o,
  output logic signed [15:0]                  left_out_o,
  output logic signed [15:0]                  right_out_o,
  output logic                                sound_done_o,
  output logic                                beyond_buffer_o
);

  localparam int unsigned AW = $clog2(BUFFER_FRAMES);
  localparam int unsigned CW = pcmrv_pkg::CNT_W;
  localparam int unsigned PW = pcmrv_pkg::PHASE_W;
  localparam int unsigned KW = pcmrv_pkg::RES_CNT_W;

  logic [15:0]                    rate_cfg_q;
  logic                           stereo_q, dock_q;
  logic [pcmrv_pkg::GAIN_W-1:0]   vol_q;

  logic                           op_q, fin_q, resample_q, total_ok_q;
  logic signed [15:0]             cur_l_q, cur_r_q, prev_l_q, prev_r_q;
  logic [pcmrv_pkg::GAIN_W-1:0]   g_q;
  logic [15:0]                    rate_q, step_q;
  logic [KW-1:0]                  k_q;
  logic                           have_prev_q;
  logic [PW-1:0]                  phase_q;
  logic [CW-1:0]                  oc_q, sfc_q, filled_q, total_q;

  logic                           hold_q, mix_q, beyond_q;
  logic signed [15:0]             lerp_l_q, lerp_r_q, scl_l_q, scl_r_q;
  logic [31:0]                    old_q;

  logic                           out_vld_q, out_done_q, out_beyond_q;
  logic [pcmrv_pkg::FRAME_IDX_W-1:0] out_idx_q;
  logic signed [15:0]             out_l_q, out_r_q;

  logic [31:0]                    mem [BUFFER_FRAMES];

  logic [15:0]                    rate_eff;
  logic [pcmrv_pkg::GAIN_W-1:0]   g_sat, g_eff;
  logic [CW:0]                    frames;
  logic [CW-1:0]                  total_eff;
  logic [pcmrv_pkg::DIV_W-1:0]    dividend, quotient;
  logic [15:0]                    divisor;
  logic                           div_done;
  logic [pcmrv_pkg::STEP_PROD_W-1:0] step_prod;
  logic [15:0]                    step_c;

  logic signed [15:0]             a_l, a_r;
  logic [15:0]                    frac;
  logic signed [16:0]             d_l, d_r, sum_l, sum_r;
  logic signed [33:0]             p_l, p_r;
  logic signed [25:0]             s_l, s_r;
  logic signed [16:0]             m_l, m_r;
  logic signed [15:0]             w_l, w_r, old_l, old_r;
  logic                           beyond_c, out_free, last_c;
  logic [PW-1:0]                  phase_n;
  logic [CW-1:0]                  oc_n;
  logic [KW-1:0]                  k_n;

  function automatic logic interp_more(input logic [PW-1:0] ph, input logic [KW-1:0] k,
                                       input logic [CW-1:0] oc, input logic rs,
                                       input logic hp, input logic fn,
                                       input logic [CW-1:0] tot);
    interp_more = rs && hp && ph < pcmrv_pkg::PHASE_ONE && k < pcmrv_pkg::MAX_RES &&
                  (!fn || oc < tot);
  endfunction

  function automatic logic hold_more(input logic [KW-1:0] k, input logic [CW-1:0] oc,
                                     input logic rs, input logic fn,
                                     input logic [CW-1:0] tot);
    hold_more = rs ? (fn && oc < tot && k < pcmrv_pkg::MAX_RES) : (k == '0);
  endfunction

  always_comb begin
    if (rate_cfg_q == '0 || rate_cfg_q >= pcmrv_pkg::TARGET_HZ) begin
      rate_eff = pcmrv_pkg::TARGET_HZ;
    end else if (rate_cfg_q < pcmrv_pkg::MIN_HZ) begin
      rate_eff = pcmrv_pkg::MIN_HZ;
    end else begin
      rate_eff = rate_cfg_q;
    end
    g_sat = (vol_q > pcmrv_pkg::GAIN_MAX) ? pcmrv_pkg::GAIN_MAX : vol_q;
    g_eff = dock_q ? (g_sat >> 1) : g_sat;
  end

  assign step_prod = rate_eff * pcmrv_pkg::STEP_MUL;
  assign step_c    = step_prod[pcmrv_pkg::STEP_SHIFT+15:pcmrv_pkg::STEP_SHIFT];

  assign frames    = {1'b0, sfc_q} + 1'b1;
  assign total_eff = resample_q ? total_q : frames[CW-1:0];

  assign dividend = pcmrv_pkg::DIV_W'(frames) * pcmrv_pkg::DIV_W'(pcmrv_pkg::TARGET_HZ) +
                    pcmrv_pkg::DIV_W'(rate_q) - 1'b1;
  assign divisor  = rate_q;

  pcmrv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .take_i     (cmd_i.div_take),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    a_l   = cmd_i.hold ? cur_l_q : prev_l_q;
    a_r   = cmd_i.hold ? cur_r_q : prev_r_q;
    frac  = cmd_i.hold ? 16'h0000 : phase_q[15:0];
    d_l   = {cur_l_q[15], cur_l_q} - {a_l[15], a_l};
    d_r   = {cur_r_q[15], cur_r_q} - {a_r[15], a_r};
    p_l   = d_l * $signed({1'b0, frac});
    p_r   = d_r * $signed({1'b0, frac});
    sum_l = {a_l[15], a_l} + p_l[32:16];
    sum_r = {a_r[15], a_r} + p_r[32:16];
    s_l   = lerp_l_q * $signed({1'b0, g_q});
    s_r   = lerp_r_q * $signed({1'b0, g_q});
  end

  always_comb begin
    old_l = old_q[15:0];
    old_r = old_q[31:16];
    m_l   = {old_l[15], old_l} + {scl_l_q[15], scl_l_q};
    m_r   = {old_r[15], old_r} + {scl_r_q[15], scl_r_q};
    if (!mix_q)                w_l = scl_l_q;
    else if (m_l[16] != m_l[15]) w_l = m_l[16] ? 16'sh8000 : 16'sh7FFF;
    else                       w_l = m_l[15:0];
    if (!mix_q)                w_r = scl_r_q;
    else if (m_r[16] != m_r[15]) w_r = m_r[16] ? 16'sh8000 : 16'sh7FFF;
    else                       w_r = m_r[15:0];
  end

  assign beyond_c = oc_q >= CW'(BUFFER_FRAMES);
  assign out_free = !out_vld_q || !out_stall_i;
  assign phase_n  = hold_q ? phase_q : phase_q + PW'(step_q);
  assign oc_n     = oc_q + 1'b1;
  assign k_n      = k_q + 1'b1;
  assign last_c   = !(interp_more(phase_n, k_n, oc_n, resample_q, have_prev_q, fin_q,
                                  total_q) ||
                      hold_more(k_n, oc_n, resample_q, fin_q, total_q));

  always_comb begin
    sts_o             = '0;
    sts_o.is_mix_op   = op_q == pcmrv_pkg::OP_BEGIN_MIX;
    sts_o.need_total  = resample_q && fin_q && !total_ok_q;
    sts_o.div_done    = div_done;
    sts_o.interp_more = interp_more(phase_q, k_q, oc_q, resample_q, have_prev_q, fin_q,
                                    total_q);
    sts_o.hold_more   = hold_more(k_q, oc_q, resample_q, fin_q, total_q);
    sts_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_cfg_q  <= pcmrv_pkg::RATE_RESET;
      stereo_q    <= 1'b0;
      vol_q       <= pcmrv_pkg::VOLUME_RESET;
      dock_q      <= 1'b0;
      total_ok_q  <= 1'b0;
      op_q        <= pcmrv_pkg::OP_FRAME;
      fin_q       <= 1'b0;
      resample_q  <= 1'b0;
      k_q         <= '0;
      have_prev_q <= 1'b0;
      phase_q     <= '0;
      oc_q        <= '0;
      sfc_q       <= '0;
      filled_q    <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pcmrv_pkg::CFG_SOURCE_RATE:    rate_cfg_q <= cfg_data_i[15:0];
          pcmrv_pkg::CFG_STEREO_SOURCE:  stereo_q <= cfg_data_i[0];
          pcmrv_pkg::CFG_VOLUME:         vol_q    <= cfg_data_i[pcmrv_pkg::GAIN_W-1:0];
          pcmrv_pkg::CFG_DOCKED_HALVING: dock_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        op_q       <= operation_i;
        fin_q      <= final_frame_i;
        resample_q <= rate_eff != pcmrv_pkg::TARGET_HZ;
        total_ok_q <= 1'b0;
        k_q        <= '0;
      end
      if (cmd_i.div_take) begin
        total_ok_q <= 1'b1;
      end
      if (cmd_i.write) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.write) begin
        oc_q      <= oc_n;
        k_q       <= k_n;
        phase_q   <= phase_n;
      end
      if (cmd_i.finish) begin
        if (fin_q) begin
          if (total_eff > filled_q) begin
            filled_q <= total_eff;
          end
          oc_q        <= '0;
          phase_q     <= '0;
          sfc_q       <= '0;
          prev_l_q    <= '0;
          prev_r_q    <= '0;
          have_prev_q <= 1'b0;
        end else begin
          if (resample_q && have_prev_q) begin
            phase_q <= (phase_q >= pcmrv_pkg::PHASE_ONE) ? phase_q - pcmrv_pkg::PHASE_ONE
                                                         : '0;
          end
          if (sfc_q != '1) begin
            sfc_q <= sfc_q + 1'b1;
          end
          prev_l_q    <= cur_l_q;
          prev_r_q    <= cur_r_q;
          have_prev_q <= 1'b1;
        end
      end
      if (cmd_i.begin_mix) begin
        filled_q    <= '0;
        oc_q        <= '0;
        phase_q     <= '0;
        sfc_q       <= '0;
        prev_l_q    <= '0;
        prev_r_q    <= '0;
        have_prev_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_l_q <= left_sample_i;
      cur_r_q <= stereo_q ? right_sample_i : left_sample_i;
      g_q     <= g_eff;
      rate_q  <= rate_eff;
      step_q  <= step_c;
    end
    if (cmd_i.div_take) begin
      total_q <= quotient[CW-1:0];
    end
    if (cmd_i.lerp) begin
      hold_q   <= cmd_i.hold;
      lerp_l_q <= sum_l[15:0];
      lerp_r_q <= sum_r[15:0];
    end
    if (cmd_i.scale) begin
      scl_l_q <= s_l[23:8];
      scl_r_q <= s_r[23:8];
    end
    if (cmd_i.read) begin
      mix_q    <= !beyond_c && oc_q < filled_q;
      beyond_q <= beyond_c;
    end
    if (cmd_i.write) begin
      out_idx_q    <= oc_q[pcmrv_pkg::FRAME_IDX_W-1:0];
      out_l_q      <= w_l;
      out_r_q      <= w_r;
      out_done_q   <= fin_q && last_c;
      out_beyond_q <= beyond_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      old_q <= mem[oc_q[AW-1:0]];
    end
    if (cmd_i.write && !beyond_q) begin
      mem[oc_q[AW-1:0]] <= {w_r, w_l};
    end
  end

  assign out_valid_o     = out_vld_q;
  assign frame_index_o   = out_idx_q;
  assign left_out_o      = out_l_q;
  assign right_out_o     = out_r_q;
  assign sound_done_o    = out_done_q;
  assign beyond_buffer_o = out_beyond_q;

endmodule

FILE: hw/rtl/pcmrv_ctrl.sv
// Controller: sequences divide, interpolate, scale, read, mix/write and finish
// steps for each source word, or a begin-mix step. Depends on pcmrv_pkg.
module pcmrv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pcmrv_pkg::sts_t sts_i,
  output pcmrv_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SCALE  = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_WRITE  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PREP;
        end
      end
      S_PREP: begin
        if (sts_i.is_mix_op) begin
          cmd_o.begin_mix = 1'b1;
          state_d         = S_IDLE;
        end else if (sts_i.need_total) begin
          cmd_o.div_go = 1'b1;
          state_d      = S_DIV;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_PREP;
        end
      end
      S_DECIDE: begin
        if (sts_i.interp_more) begin
          cmd_o.lerp = 1'b1;
          state_d    = S_SCALE;
        end else if (sts_i.hold_more) begin
          cmd_o.lerp = 1'b1;
          cmd_o.hold = 1'b1;
          state_d    = S_SCALE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

FILE: hw/rtl/pcm_resample_volume_mixer_top.sv
// Top level of the PCM resample, volume and mix block.
// Depends on pcmrv_pkg, pcmrv_ctrl, pcmrv_dp (which holds pcmrv_div).

// One word is taken at a time. A source word produces 0 to 16 output frames
// (about 6 at 8 kHz), each taking the interpolate, scale, read and write steps;
// a write waits while the output side stalls. The phase step comes from a
// combinational reciprocal multiply registered at accept; the final word of a
// resampled sound runs a serial divide for the output frame count. The play
// buffer is one memory with one read and one write port, read then written per
// frame.
module pcm_resample_volume_mixer_top #(
  parameter int unsigned BUFFER_FRAMES = pcmrv_pkg::BUFFER_FRAMES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic signed [15:0]                  left_sample_i,
  input  logic signed [15:0]                  right_sample_i,
  input  logic                                final_frame_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pcmrv_pkg::FRAME_IDX_W-1:0]   frame_index_o,
  output logic signed [15:0]                  left_out_o,
  output logic signed [15:0]                  right_out_o,
  output logic                                sound_done_o,
  output logic                                beyond_buffer_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcmrv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcmrv_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  pcmrv_pkg::cmd_t cmd;
  pcmrv_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  pcmrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcmrv_dp #(
    .BUFFER_FRAMES (BUFFER_FRAMES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .final_frame_i   (final_frame_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .frame_index_o   (frame_index_o),
    .left_out_o      (left_out_o),
    .right_out_o     (right_out_o),
    .sound_done_o    (sound_done_o),
    .beyond_buffer_o (beyond_buffer_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted word did not make the block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_stall_o)
    else $error("output word appeared outside item processing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.lerp, cmd.scale, cmd.read, cmd.write, cmd.finish,
              cmd.div_go, cmd.div_take, cmd.begin_mix}))
    else $error("controller issued overlapping commands");

endmodule
